FILE: rtl/ohms_pkg.sv
// Shared types, constants and decode helpers for the obfuscated marker scanner.
`default_nettype none
package ohms_pkg;

    localparam int KEY_LIMIT   = 31;
    localparam int OFFSET_BITS = 32;
    localparam int OUT_OFF_BITS = 32;
    localparam int KEY_BITS    = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic CFG_MODE_ENABLE = 1'b0;
    localparam logic CFG_MAX_XOR_KEY = 1'b1;

    // Hit modes, also the bit positions in an item's hit mask
    localparam logic [1:0] MODE_PLAIN   = 2'd0;
    localparam logic [1:0] MODE_ROT13   = 2'd1;
    localparam logic [1:0] MODE_XOR     = 2'd2;
    localparam logic [1:0] MODE_ROT_XOR = 2'd3;

    localparam logic [KEY_BITS-1:0] KEY_NONE = '0;

    // Marker letters, lower case; upper case differs only in the case bit
    localparam logic [7:0] MARK_H   = 8'd104;
    localparam logic [7:0] MARK_T   = 8'd116;
    localparam logic [7:0] MARK_P   = 8'd112;
    localparam logic [7:0] CASE_BIT = 8'd32;
    localparam logic [7:0] ROT_STEP = 8'd13;

    typedef struct packed {
        logic [3:0]             mask;     // one bit per hit mode
        logic [KEY_BITS-1:0]    xor_key;
        logic [KEY_BITS-1:0]    rot_key;
        logic [OFFSET_BITS-1:0] offset;
    } t_scan_item;

    function automatic logic [7:0] rot13(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if ((b >= 8'd65 && b <= 8'd77) || (b >= 8'd97 && b <= 8'd109)) begin
            r = b + ROT_STEP;
        end else if ((b >= 8'd78 && b <= 8'd90) || (b >= 8'd110 && b <= 8'd122)) begin
            r = b - ROT_STEP;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/obfuscated_http_marker_scanner_unit.sv
// Top level of the obfuscated "http" marker scanner.
// Takes one file byte per cycle and reports every decoding (plain, ROT13, XOR with a key,
// ROT13 then XOR) under which the last four bytes read "http" in any letter case. Because a
// key must turn all four bytes into their letters, each XOR family has at most one matching
// key per window, so a byte yields at most two hits. The front end classifies each window in
// the cycle the byte is accepted and pushes windows with hits into a four-entry queue; the
// back end sends one hit per cycle through a result register while that register is empty or
// popped. A byte is accepted every cycle while the queue has room; the queue fills only when
// results are not popped or windows with two hits arrive back to back. A hit passes through
// the queue and then the result register before it shows on the result ports. Start of file
// clears the history, and the first three bytes of a file give no hit.
// Configuration writes are always ready and take effect on the next accepted byte.
`default_nettype none
module obfuscated_http_marker_scanner_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              push,
    output      logic                              full,
    input  wire logic [7:0]                        i_data_byte,
    input  wire logic                              i_start_of_file,
    output      logic                              empty,
    input  wire logic                              pop,
    output      logic [1:0]                        o_hit_mode,
    output      logic [ohms_pkg::KEY_BITS-1:0]     o_hit_key,
    output      logic [ohms_pkg::OUT_OFF_BITS-1:0] o_hit_offset,
    output      logic                              o_last_hit,
    input  wire logic                              i_cfg_valid,
    output      logic                              o_cfg_ready,
    input  wire logic                              i_cfg_index,
    input  wire logic [ohms_pkg::KEY_BITS-1:0]     i_cfg_data
);
    import ohms_pkg::*;

    logic [3:0]          r_mode_enable;
    logic [KEY_BITS-1:0] r_max_xor_key;

    logic       accept;
    logic       front_hit;
    t_scan_item front_item;
    t_scan_item q_item;
    logic       q_full, q_empty, q_rd;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign accept      = push && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_enable <= 4'd15;
            r_max_xor_key <= KEY_BITS'(31);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE_ENABLE: r_mode_enable <= i_cfg_data[3:0];
                CFG_MAX_XOR_KEY: r_max_xor_key <= i_cfg_data;
            endcase
        end
    end

    ohms_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .i_mode_enable   (r_mode_enable),
        .i_max_xor_key   (r_max_xor_key),
        .o_hit           (front_hit),
        .o_item          (front_item)
    );

    ohms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_hit),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    ohms_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_item     (q_item),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_hit_mode   (o_hit_mode),
        .o_hit_key    (o_hit_key),
        .o_hit_offset (o_hit_offset),
        .o_last_hit   (o_last_hit)
    );

endmodule
`default_nettype wire

FILE: rtl/ohms_front.sv
// Front end: byte history, offset counter and per-window classification of all decodings.
`default_nettype none
module ohms_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [7:0]                  i_data_byte,
    input  wire logic                        i_start_of_file,
    input  wire logic [3:0]                  i_mode_enable,
    input  wire logic [ohms_pkg::KEY_BITS-1:0] i_max_xor_key,
    output      logic                        o_hit,
    output      ohms_pkg::t_scan_item        o_item
);
    import ohms_pkg::*;

    logic [7:0]             r_hist [3];
    logic [1:0]             r_fill;
    logic [OFFSET_BITS-1:0] r_offset;

    logic [7:0]             w [4];
    logic [7:0]             rw [4];
    logic [7:0]             mark [4];
    logic [7:0]             ex [4];
    logic [7:0]             er [4];
    logic [1:0]             fill_eff;
    logic [OFFSET_BITS-1:0] off_eff;
    logic                   plain_ok, rot_ok, xeq, req;
    logic                   x_ok, r_ok;

    assign mark[0] = MARK_H;
    assign mark[1] = MARK_T;
    assign mark[2] = MARK_T;
    assign mark[3] = MARK_P;

    always_comb begin
        fill_eff = i_start_of_file ? 2'd0 : r_fill;
        off_eff  = i_start_of_file ? '0 : r_offset;
        w[0] = i_start_of_file ? 8'd0 : r_hist[0];
        w[1] = i_start_of_file ? 8'd0 : r_hist[1];
        w[2] = i_start_of_file ? 8'd0 : r_hist[2];
        w[3] = i_data_byte;
        // A letter matches when the byte with its case bit set equals the lower case code,
        // so an xor key must equal that difference on all four bytes.
        for (int i = 0; i < 4; i++) begin
            rw[i] = rot13(w[i]);
            ex[i] = (w[i] | CASE_BIT) ^ mark[i];
            er[i] = (rw[i] | CASE_BIT) ^ mark[i];
        end
        plain_ok = (ex[0] == 8'd0) && (ex[1] == 8'd0) && (ex[2] == 8'd0) && (ex[3] == 8'd0);
        rot_ok   = (er[0] == 8'd0) && (er[1] == 8'd0) && (er[2] == 8'd0) && (er[3] == 8'd0);
        xeq = (ex[0] == ex[1]) && (ex[0] == ex[2]) && (ex[0] == ex[3]);
        req = (er[0] == er[1]) && (er[0] == er[2]) && (er[0] == er[3]);
        x_ok = xeq && (ex[0][7:KEY_BITS] == '0) && (ex[0][KEY_BITS-1:0] != KEY_NONE)
            && (ex[0][KEY_BITS-1:0] <= i_max_xor_key)
            && (32'(ex[0][KEY_BITS-1:0]) <= 32'(KEY_LIMIT));
        r_ok = req && (er[0][7:KEY_BITS] == '0) && (er[0][KEY_BITS-1:0] != KEY_NONE)
            && (er[0][KEY_BITS-1:0] <= i_max_xor_key)
            && (32'(er[0][KEY_BITS-1:0]) <= 32'(KEY_LIMIT));

        o_item.mask[MODE_PLAIN]   = plain_ok & i_mode_enable[MODE_PLAIN];
        o_item.mask[MODE_ROT13]   = rot_ok   & i_mode_enable[MODE_ROT13];
        o_item.mask[MODE_XOR]     = x_ok     & i_mode_enable[MODE_XOR];
        o_item.mask[MODE_ROT_XOR] = r_ok     & i_mode_enable[MODE_ROT_XOR];
        if (fill_eff != 2'd3) begin
            o_item.mask = '0;
        end
        o_item.xor_key = ex[0][KEY_BITS-1:0];
        o_item.rot_key = er[0][KEY_BITS-1:0];
        o_item.offset  = off_eff - OFFSET_BITS'(3);
        o_hit = i_accept && (o_item.mask != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist[0] <= '0;
            r_hist[1] <= '0;
            r_hist[2] <= '0;
            r_fill    <= '0;
            r_offset  <= '0;
        end else if (i_accept) begin
            r_hist[0] <= w[1];
            r_hist[1] <= w[2];
            r_hist[2] <= w[3];
            if (fill_eff != 2'd3) begin
                r_fill <= fill_eff + 2'd1;
            end else begin
                r_fill <= fill_eff;
            end
            r_offset <= off_eff + OFFSET_BITS'(1);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ohms_queue.sv
// Short queue of classified windows between the front end and the result serializer.
`default_nettype none
module ohms_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  wire ohms_pkg::t_scan_item i_item,
    output      logic                 o_full,
    input  wire logic                 i_rd,
    output      logic                 o_empty,
    output      ohms_pkg::t_scan_item o_item
);
    import ohms_pkg::*;

    t_scan_item           r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;

    assign o_full  = (r_count == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + (QPTR_BITS+1)'(1);
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - (QPTR_BITS+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ohms_back.sv
// Back end: walks each queued hit mask in mode order and drives the result register.
`default_nettype none
module ohms_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_empty,
    input  wire ohms_pkg::t_scan_item i_q_item,
    output      logic                 o_q_rd,
    input  wire logic                 i_pop,
    output      logic                 o_empty,
    output      logic [1:0]           o_hit_mode,
    output      logic [ohms_pkg::KEY_BITS-1:0] o_hit_key,
    output      logic [ohms_pkg::OUT_OFF_BITS-1:0] o_hit_offset,
    output      logic                 o_last_hit
);
    import ohms_pkg::*;

    logic [3:0]              r_done;
    logic                    r_valid;
    logic [1:0]              r_mode;
    logic [KEY_BITS-1:0]     r_key;
    logic [OUT_OFF_BITS-1:0] r_offset;
    logic                    r_last;

    logic [3:0]          remain, cur, rest;
    logic [1:0]          cur_mode;
    logic [KEY_BITS-1:0] cur_key;
    logic                advance, emit;

    always_comb begin
        remain   = i_q_item.mask & ~r_done;
        cur      = '0;
        cur_mode = MODE_PLAIN;
        cur_key  = KEY_NONE;
        priority if (remain[MODE_PLAIN]) begin
            cur[MODE_PLAIN] = 1'b1;
        end else if (remain[MODE_ROT13]) begin
            cur[MODE_ROT13] = 1'b1;
            cur_mode = MODE_ROT13;
        end else if (remain[MODE_XOR]) begin
            cur[MODE_XOR] = 1'b1;
            cur_mode = MODE_XOR;
            cur_key  = i_q_item.xor_key;
        end else begin
            cur[MODE_ROT_XOR] = 1'b1;
            cur_mode = MODE_ROT_XOR;
            cur_key  = i_q_item.rot_key;
        end
        rest    = remain & ~cur;
        advance = !r_valid || i_pop;
        emit    = advance && !i_q_empty;
        o_q_rd  = emit && (rest == '0);
    end

    assign o_empty      = !r_valid;
    assign o_hit_mode   = r_mode;
    assign o_hit_key    = r_key;
    assign o_hit_offset = r_offset;
    assign o_last_hit   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            if (advance) begin
                r_valid <= !i_q_empty;
            end
            // drop the finished item's progress, otherwise mark the hit just sent
            if (o_q_rd) begin
                r_done <= '0;
            end else if (emit) begin
                r_done <= r_done | cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_mode   <= cur_mode;
            r_key    <= cur_key;
            r_offset <= OUT_OFF_BITS'(i_q_item.offset);
            r_last   <= (rest == '0);
        end
    end

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the obfuscated http marker scanner: directed table plus random phases.
`timescale 1ns / 1ps
module tb_top;
    import ohms_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int WATCHDOG      = 3000;

    typedef struct packed {
        logic [1:0]          mode;
        logic [KEY_BITS-1:0] key;
        logic [31:0]         off;
        logic                is_last;
    } t_marker_hit;

    typedef struct packed {
        logic [7:0]          data;
        logic                sof;
        logic                typed;
        logic                hit;
        logic [1:0]          mode;
        logic [KEY_BITS-1:0] key;
    } t_dir_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    logic [7:0]              i_data_byte = 8'd0;
    logic                    i_start_of_file = 1'b0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic [1:0]              o_hit_mode;
    logic [KEY_BITS-1:0]     o_hit_key;
    logic [OUT_OFF_BITS-1:0] o_hit_offset;
    logic                    o_last_hit;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic                    i_cfg_index = 1'b0;
    logic [KEY_BITS-1:0]     i_cfg_data = '0;

    // Side data that travels with each byte request
    logic                    row_typed = 1'b0;
    logic                    row_hit = 1'b0;
    logic [1:0]              row_mode = MODE_PLAIN;
    logic [KEY_BITS-1:0]     row_key = KEY_NONE;

    // Scanner shadow state
    logic [3:0]              mode_en = 4'hf;
    logic [KEY_BITS-1:0]     max_key = 5'd31;
    logic [23:0]             hist = '0;
    logic [1:0]              hist_fill = 2'd0;
    logic [OFFSET_BITS-1:0]  next_off = '0;

    t_marker_hit             new_hits[$];
    t_marker_hit             hits_due[$];
    t_dir_row                dir_rows[$];

    int                      tx_idle_pct = 0;
    int                      rx_stall_pct = 0;
    bit                      hold_req = 1'b0;
    int                      errors = 0;
    int                      bytes_in = 0;
    int                      hits_seen = 0;
    int                      cfg_writes = 0;
    int                      quiet = 0;

    obfuscated_http_marker_scanner_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .empty           (empty),
        .pop             (pop),
        .o_hit_mode      (o_hit_mode),
        .o_hit_key       (o_hit_key),
        .o_hit_offset    (o_hit_offset),
        .o_last_hit      (o_last_hit),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [7:0] rot_byte(input logic [7:0] b);
        logic [7:0] lc;
        lc = b | 8'h20;
        if (lc >= 8'h61 && lc <= 8'h6d) begin
            return b + 8'd13;
        end
        if (lc >= 8'h6e && lc <= 8'h7a) begin
            return b - 8'd13;
        end
        return b;
    endfunction

    // Window is packed oldest byte first; a letter matches in either case
    function automatic bit decodes_to_marker(input logic [31:0] win, input bit rot,
                                             input logic [KEY_BITS-1:0] key);
        logic [31:0] mark;
        logic [7:0]  d;
        int          i;
        mark = {8'h68, 8'h74, 8'h74, 8'h70};
        for (i = 0; i < 4; i++) begin
            d = win[31-8*i -: 8];
            if (rot) begin
                d = rot_byte(d);
            end
            d = d ^ {3'b000, key};
            if ((d | 8'h20) != mark[31-8*i -: 8]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void predict_hits(input logic [7:0] b, input logic sof);
        logic [31:0] win;
        logic [31:0] hoff;
        t_marker_hit tail;
        int          k;
        new_hits.delete();
        if (sof) begin
            hist      = '0;
            hist_fill = 2'd0;
            next_off  = '0;
        end
        if (hist_fill == 2'd3) begin
            win  = {hist, b};
            hoff = next_off - 32'd3;
            if (mode_en[0] && decodes_to_marker(win, 1'b0, KEY_NONE)) begin
                new_hits.push_back({MODE_PLAIN, KEY_NONE, hoff, 1'b0});
            end
            if (mode_en[1] && decodes_to_marker(win, 1'b1, KEY_NONE)) begin
                new_hits.push_back({MODE_ROT13, KEY_NONE, hoff, 1'b0});
            end
            if (mode_en[2]) begin
                for (k = 1; k <= max_key; k++) begin
                    if (decodes_to_marker(win, 1'b0, 5'(k))) begin
                        new_hits.push_back({MODE_XOR, 5'(k), hoff, 1'b0});
                    end
                end
            end
            if (mode_en[3]) begin
                for (k = 1; k <= max_key; k++) begin
                    if (decodes_to_marker(win, 1'b1, 5'(k))) begin
                        new_hits.push_back({MODE_ROT_XOR, 5'(k), hoff, 1'b0});
                    end
                end
            end
            if (new_hits.size() > 0) begin
                tail = new_hits.pop_back();
                tail.is_last = 1'b1;
                new_hits.push_back(tail);
            end
        end
        hist = {hist[15:0], b};
        if (hist_fill != 2'd3) begin
            hist_fill = hist_fill + 2'd1;
        end
        next_off = next_off + 32'd1;
    endfunction

    function automatic t_dir_row mk_row(input logic [7:0] data, input logic sof,
                                        input logic typed, input logic hit,
                                        input logic [1:0] mode, input logic [KEY_BITS-1:0] key);
        return {data, sof, typed, hit, mode, key};
    endfunction

    // Monitor: track config, predict on every accepted byte, check every popped hit
    always @(posedge i_clk) begin : monitor
        t_marker_hit got;
        t_marker_hit want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_writes++;
                if (i_cfg_index == CFG_MODE_ENABLE) begin
                    mode_en = i_cfg_data[3:0];
                end else begin
                    max_key = i_cfg_data;
                end
            end
            if (push && !full) begin
                bytes_in++;
                predict_hits(i_data_byte, i_start_of_file);
                if (row_typed) begin
                    if (row_hit) begin
                        hits_due.push_back({row_mode, row_key, 32'd0, 1'b1});
                    end
                end else begin
                    foreach (new_hits[j]) begin
                        hits_due.push_back(new_hits[j]);
                    end
                end
            end
            if (pop && !empty) begin
                got = {o_hit_mode, o_hit_key, o_hit_offset, o_last_hit};
                if (hits_due.size() == 0) begin
                    errors++;
                    $display("%0t: expected no hit, got mode %0d key %0d offset %0d last %0d",
                             $time, got.mode, got.key, got.off, got.is_last);
                end else begin
                    want = hits_due.pop_front();
                    hits_seen++;
                    if (got.mode !== want.mode || got.key !== want.key ||
                        got.off !== want.off || got.is_last !== want.is_last) begin
                        errors++;
                        $display("%0t: hit mismatch, expected mode %0d key %0d offset %0d last %0d",
                                 $time, want.mode, want.key, want.off, want.is_last);
                        $display("%0t:   got mode %0d key %0d offset %0d last %0d",
                                 $time, got.mode, got.key, got.off, got.is_last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin : receiver
        int hold_cnt;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) begin
                    @(negedge i_clk);
                end
            end
            pop <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Keep push high across back-to-back requests; drop it only for idle cycles
    task automatic send_byte(input logic [7:0] b, input logic sof, input logic typed,
                             input logic hit, input logic [1:0] mode,
                             input logic [KEY_BITS-1:0] key);
        @(negedge i_clk);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push            <= 1'b1;
        i_data_byte     <= b;
        i_start_of_file <= sof;
        row_typed       <= typed;
        row_hit         <= hit;
        row_mode        <= mode;
        row_key         <= key;
        do @(posedge i_clk); while (full);
    endtask

    task automatic write_reg(input logic idx, input logic [KEY_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_results;
        @(negedge i_clk);
        push <= 1'b0;
        while (hits_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly encoded markers with random case, family and key; some corrupted, rest noise
    task automatic run_phase(input logic [KEY_BITS-1:0] me_word,
                             input logic [KEY_BITS-1:0] key_lim,
                             input int tx_pct, input int rx_pct, input int n_bytes,
                             input bit squeeze);
        logic [31:0]         mark;
        logic [7:0]          l;
        logic [1:0]          fam;
        logic [KEY_BITS-1:0] key;
        int                  sent;
        int                  bad;
        int                  i;
        mark = {8'h68, 8'h74, 8'h74, 8'h70};
        drain_results();
        write_reg(CFG_MODE_ENABLE, me_word);
        write_reg(CFG_MAX_XOR_KEY, key_lim);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (squeeze) begin
            hold_req = 1'b1;
        end
        sent = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(99) < 65) begin
                fam = 2'($urandom_range(3));
                key = fam[1] ? 5'($urandom_range(31, 1)) : KEY_NONE;
                bad = ($urandom_range(99) < 15) ? $urandom_range(3) : 4;
                for (i = 0; i < 4; i++) begin
                    l = mark[31-8*i -: 8];
                    if ($urandom_range(1)) begin
                        l = l & 8'hdf;
                    end
                    if (fam[1]) begin
                        l = l ^ {3'b000, key};
                    end
                    if (fam[0]) begin
                        l = rot_byte(l);
                    end
                    if (i == bad) begin
                        l = l ^ (8'h01 << $urandom_range(7));
                    end
                    send_byte(l, (i == 0) && ($urandom_range(9) == 0), 1'b0, 1'b0,
                              MODE_PLAIN, KEY_NONE);
                    sent++;
                end
            end else begin
                repeat ($urandom_range(3, 1)) begin
                    send_byte(8'($urandom_range(255)), $urandom_range(19) == 0, 1'b0, 1'b0,
                              MODE_PLAIN, KEY_NONE);
                    sent++;
                end
            end
        end
    endtask

    initial begin : stimulus
        int r;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Each typed marker starts with start of file, so its hit sits at offset zero
        dir_rows.push_back(mk_row(8'h68, 1'b1, 1'b1, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h74, 1'b0, 1'b1, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h74, 1'b0, 1'b1, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h70, 1'b0, 1'b1, 1'b1, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h48, 1'b1, 1'b1, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h54, 1'b0, 1'b1, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h54, 1'b0, 1'b1, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h50, 1'b0, 1'b1, 1'b1, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h00, 1'b0, 1'b0, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'hff, 1'b0, 1'b0, 1'b0, MODE_PLAIN, KEY_NONE));
        // "http" under xor with the largest key, then "http" under rot13
        dir_rows.push_back(mk_row(8'h77, 1'b1, 1'b1, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h6b, 1'b0, 1'b1, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h6b, 1'b0, 1'b1, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h6f, 1'b0, 1'b1, 1'b1, MODE_XOR, 5'd31));
        dir_rows.push_back(mk_row(8'h75, 1'b1, 1'b1, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h67, 1'b0, 1'b1, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h67, 1'b0, 1'b1, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h63, 1'b0, 1'b1, 1'b1, MODE_ROT13, KEY_NONE));
        // Mixed case "HTtP" under rot13 then xor with key 1
        dir_rows.push_back(mk_row(8'h56, 1'b1, 1'b1, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h48, 1'b0, 1'b1, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h68, 1'b0, 1'b1, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h44, 1'b0, 1'b1, 1'b1, MODE_ROT_XOR, 5'd1));
        // Start of file inside a marker leaves too short a history
        dir_rows.push_back(mk_row(8'h68, 1'b0, 1'b0, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h74, 1'b0, 1'b0, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h74, 1'b1, 1'b1, 1'b0, MODE_PLAIN, KEY_NONE));
        dir_rows.push_back(mk_row(8'h70, 1'b0, 1'b1, 1'b0, MODE_PLAIN, KEY_NONE));

        for (r = 0; r < dir_rows.size(); r++) begin
            send_byte(dir_rows[r].data, dir_rows[r].sof, dir_rows[r].typed, dir_rows[r].hit,
                      dir_rows[r].mode, dir_rows[r].key);
        end

        run_phase(5'h1f, 5'd0, 0, 0, 50, 1'b0);
        run_phase(5'h00, 5'd31, 88, 0, 40, 1'b0);
        run_phase(5'h05, 5'd1, 0, 88, 60, 1'b0);
        run_phase(5'h0a, 5'd31, 27, 27, 60, 1'b0);
        run_phase(5'h0f, 5'd31, 0, 0, 60, 1'b1);
        run_phase(5'h03, 5'd16, 88, 0, 60, 1'b0);
        run_phase(5'h0c, 5'($urandom_range(31, 1)), 0, 88, 60, 1'b0);
        run_phase(5'h0f, 5'd31, 27, 27, 60, 1'b0);
        run_phase(5'($urandom_range(31)), 5'($urandom_range(31)), 0, 0, 50, 1'b0);
        drain_results();

        $display("Scanned %0d bytes with %0d register writes; %0d hits compared, %0d errors.",
                 bytes_in, cfg_writes, hits_seen, errors);
        $display("Mix: all four decode families, start-of-file resets, zero key limit,");
        $display("     idle and stall phases, and a long hold-off that fills the queue.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/ohms_pkg.sv
rtl/ohms_front.sv
rtl/ohms_queue.sv
rtl/ohms_back.sv
rtl/obfuscated_http_marker_scanner_unit.sv
test/tb_top.sv
